### src/rlbp_pkg.sv
// Package for the RGB LED breath pattern block: word types, slot type, sequencer states,
// shared compare unit interface and the constant tables of the pattern arithmetic.
// Depends on nothing; every other file in src imports it.
package rlbp_pkg;

   localparam int SLOT_COUNT = 3;
   localparam int MS_PER_SEC = 1000;

   localparam logic [1:0] CMD_BATTERY   = 2'd0;
   localparam logic [1:0] CMD_NOTIFY    = 2'd1;
   localparam logic [1:0] CMD_ATTENTION = 2'd2;
   localparam logic [1:0] CMD_IGNORE    = 2'd3;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_TIMED = 2'd1;
   localparam logic [1:0] MODE_HW    = 2'd2;

   localparam logic [1:0] COL_LAST       = 2'd2;
   localparam logic [2:0] SNAP_LAST      = 3'd4;
   localparam logic [2:0] SNAP_TOP_EXP   = 3'd5;
   localparam logic [2:0] FADE_LAST      = 3'd6;
   localparam logic [2:0] FADE_DEFAULT   = 3'd2;
   localparam logic [2:0] ON_SEC_IDLE    = 3'd3;
   localparam logic [2:0] OFF_SEC_IDLE   = 3'd4;
   localparam logic [2:0] ON_SEC_MAX     = 3'd5;
   localparam logic [2:0] OFF_SEC_MAX    = 3'd7;
   localparam logic [2:0] MASK_ALL       = 3'b111;
   localparam logic [7:0] FALLBACK_LEVEL = 8'd127;
   localparam logic [7:0] LEVEL_MAX      = 8'd255;

   typedef struct packed {
      logic [1:0]  command;
      logic [23:0] color;
      logic [1:0]  flash_mode;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic [2:0] red_ramp;
      logic [2:0] green_ramp;
      logic [2:0] blue_ramp;
      logic [2:0] on_seconds;
      logic [2:0] off_seconds;
      logic [2:0] blink_mask;
      logic [1:0] active_source;
   } rsp_word_type;

   typedef struct packed {
      logic [23:0] color;
      logic [1:0]  flash_mode;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } slot_type;

   typedef struct packed {
      logic [15:0] lhs;
      logic [7:0]  factor;
      logic [7:0]  base;
   } cmp_req_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_SNAP,
      ST_RESCALE,
      ST_PEAK,
      ST_FADE,
      ST_FINISH
   } seq_state_type;

   // A scaled level q = 256 * c / top lies at or below threshold T exactly when
   // 256 * c < (T + 1) * top; these are the factors T + 1 of the grid edges.
   function automatic logic [7:0] snap_factor(input logic [2:0] idx);
      logic [7:0] factor;
      unique case (idx)
         3'd0:    factor = 8'd13;
         3'd1:    factor = 8'd25;
         3'd2:    factor = 8'd49;
         3'd3:    factor = 8'd97;
         default: factor = 8'd193;
      endcase
      return factor;
   endfunction

endpackage

### src/rgb_led_breath_pattern.sv
// Top level of the RGB LED breath pattern block: request slot store and sequencer.
// Depends on rlbp_pkg, rlbp_slots, rlbp_seq and, through it, rlbp_cmp.
//
// Each request word overwrites the battery, notification or attention slot (command
// value 3 writes nothing) and yields one result word for the slot then shown, chosen
// as attention if lit, then notification, then battery. One word is handled at a time
// and req_stall stays high until its result sits in the output register; the next
// word may then be taken while that result still waits on rsp_stall. A slot that is
// not blinking goes from selection straight to the result. For a timed blink the
// shared compare unit is stepped through up to five grid thresholds for each colour
// to snap the levels; after rescaling and peak search it is stepped through up to
// seven shift ratios for each colour to find the fades, and then the result is made.
// All slots read as off after reset.
module rgb_led_breath_pattern (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rlbp_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rlbp_pkg::rsp_word_type rsp_data
);
   import rlbp_pkg::*;

   slot_type   shown;
   logic [1:0] source;
   logic       accept;

   assign accept = req_valid && !req_stall;

   rlbp_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .write_en (accept),
      .req_word (req_data),
      .shown    (shown),
      .source   (source)
   );

   rlbp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .shown     (shown),
      .source    (source),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept : assert property (
      @(posedge clock) disable iff (reset) accept |=> req_stall
   ) else $error("request side not held off after a word was accepted");

   a_result_from_work : assert property (
      @(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("result word appeared without a word in progress");

   a_seconds_nonzero : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.on_seconds != 3'd0 && rsp_data.off_seconds != 3'd0
   ) else $error("blink time of zero seconds in result word");

   a_dark_blink : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.blink_mask == 3'd0 && rsp_data.on_seconds != ON_SEC_IDLE |->
      rsp_data.red_level == 8'd0 && rsp_data.green_level == 8'd0 &&
      rsp_data.blue_level == 8'd0
   ) else $error("blinking result with no colour enabled yet levels lit");

endmodule

### src/rlbp_cmp.sv
// Shared compare unit of the RGB LED breath pattern block: one small product and a
// magnitude and equality compare against it. Depends on rlbp_pkg.
module rlbp_cmp (
   input  rlbp_pkg::cmp_req_type cmp_req,
   output rlbp_pkg::cmp_rsp_type cmp_rsp
);
   import rlbp_pkg::*;

   logic [15:0] product;

   assign product       = 16'(cmp_req.factor) * 16'(cmp_req.base);
   assign cmp_rsp.less  = cmp_req.lhs < product;
   assign cmp_rsp.equal = cmp_req.lhs == product;

endmodule

### src/rlbp_slots.sv
// Request slot store of the RGB LED breath pattern block: the three light requests and
// the priority choice of the slot shown. Depends on rlbp_pkg.
module rlbp_slots (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   write_en,
   input  rlbp_pkg::req_word_type req_word,
   output rlbp_pkg::slot_type     shown,
   output logic [1:0]             source
);
   import rlbp_pkg::*;

   slot_type slot_ff [SLOT_COUNT];
   slot_type entry;

   always_comb begin
      entry.color      = req_word.color;
      entry.flash_mode = req_word.flash_mode;
      entry.on_ms      = req_word.on_ms;
      entry.off_ms     = req_word.off_ms;
      // An attention request without flashing switches the attention light off.
      if (req_word.command == CMD_ATTENTION) begin
         if (req_word.flash_mode == MODE_HW) begin
            if (req_word.on_ms != 16'd0 && req_word.off_ms == 16'd0) begin
               entry.flash_mode = MODE_NONE;
            end
         end else if (req_word.flash_mode == MODE_NONE) begin
            entry.color = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (write_en && req_word.command != CMD_IGNORE) begin
         slot_ff[req_word.command] <= entry;
      end
   end

   always_comb begin
      priority if (slot_ff[CMD_ATTENTION].color != '0) begin
         source = CMD_ATTENTION;
         shown  = slot_ff[CMD_ATTENTION];
      end else if (slot_ff[CMD_NOTIFY].color != '0) begin
         source = CMD_NOTIFY;
         shown  = slot_ff[CMD_NOTIFY];
      end else begin
         source = CMD_BATTERY;
         shown  = slot_ff[CMD_BATTERY];
      end
   end

endmodule

### src/rlbp_seq.sv
// Sequencer of the RGB LED breath pattern block: grid snapping, rescaling and fade
// search stepped through the shared compare unit, and the result word register.
// Depends on rlbp_pkg and rlbp_cmp.
module rlbp_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  rlbp_pkg::slot_type     shown,
   input  logic [1:0]             source,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rlbp_pkg::rsp_word_type rsp_data
);
   import rlbp_pkg::*;

   seq_state_type state_ff, state_in;
   logic [1:0]    col_ff, col_in;
   logic [2:0]    step_ff, step_in;
   logic [7:0]    lvl_ff [3];
   logic [7:0]    lvl_in [3];
   logic [2:0]    exp_ff [3];
   logic [2:0]    exp_in [3];
   logic [2:0]    fade_ff [3];
   logic [2:0]    fade_in [3];
   logic [7:0]    top_ff, top_in;
   logic          blink_ff, blink_in;
   logic          bad_ff, bad_in;
   logic [2:0]    onsec_ff, onsec_in;
   logic [2:0]    offsec_ff, offsec_in;
   logic [1:0]    src_ff, src_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   cmp_req_type cmp_req;
   cmp_rsp_type cmp_rsp;

   logic [7:0]   sel_lvl [3];
   logic [7:0]   sel_top;
   logic         sel_blink;
   logic [7:0]   cur_lvl;
   logic         last_col;
   logic         snap_done;
   logic         fade_done;
   logic         out_free;
   logic [1:0]   next_col;
   logic [7:0]   part [3];
   logic [7:0]   lo;
   logic [2:0]   emin;
   logic [11:0]  grown [3];
   logic [7:0]   scaled [3];
   logic [7:0]   peak;
   rsp_word_type result;

   function automatic logic [2:0] seconds_of(input logic [15:0] ms, input logic [2:0] limit);
      logic [2:0] sec;
      sec = 3'd1;
      for (int k = 2; k <= 7; k++) begin
         if (k <= int'(limit) && ms >= 16'(k * MS_PER_SEC)) begin
            sec = 3'(k);
         end
      end
      return sec;
   endfunction

   rlbp_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   assign sel_lvl[0] = shown.color[23:16];
   assign sel_lvl[1] = shown.color[15:8];
   assign sel_lvl[2] = shown.color[7:0];
   assign sel_blink  = shown.flash_mode == MODE_TIMED && shown.on_ms != 16'd0 &&
                       shown.off_ms != 16'd0;

   always_comb begin
      sel_top = sel_lvl[0];
      if (sel_lvl[1] > sel_top) sel_top = sel_lvl[1];
      if (sel_lvl[2] > sel_top) sel_top = sel_lvl[2];
      peak = lvl_ff[0];
      if (lvl_ff[1] > peak) peak = lvl_ff[1];
      if (lvl_ff[2] > peak) peak = lvl_ff[2];
   end

   assign cur_lvl   = lvl_ff[col_ff];
   assign last_col  = col_ff == COL_LAST;
   assign next_col  = last_col ? 2'd0 : col_ff + 2'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_done = cmp_rsp.less || step_ff == SNAP_LAST;
   assign fade_done = cur_lvl == 8'd0 || cmp_rsp.equal || step_ff == FADE_LAST;

   always_comb begin
      cmp_req.base = top_ff;
      if (state_ff == ST_SNAP) begin
         cmp_req.lhs    = {cur_lvl, 8'h00};
         cmp_req.factor = snap_factor(step_ff);
      end else begin
         cmp_req.lhs    = {8'h00, cur_lvl} << step_ff;
         cmp_req.factor = 8'd1;
      end
   end

   // Snapped levels become top >> (5 - e), or zero where e is 0; they are then rebuilt as
   // powers of two of the least non-zero part.
   always_comb begin
      lo   = '0;
      emin = '0;
      for (int i = 0; i < 3; i++) begin
         part[i] = (exp_ff[i] == 3'd0) ? 8'd0 : top_ff >> (SNAP_TOP_EXP - exp_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         if (part[i] != 8'd0 && (lo == 8'd0 || part[i] < lo)) lo = part[i];
         if (exp_ff[i] != 3'd0 && (emin == 3'd0 || exp_ff[i] < emin)) emin = exp_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         grown[i] = {4'h0, lo} << (exp_ff[i] - emin);
         if (exp_ff[i] == 3'd0) begin
            scaled[i] = 8'd0;
         end else if (grown[i] > 12'(LEVEL_MAX)) begin
            scaled[i] = LEVEL_MAX;
         end else begin
            scaled[i] = grown[i][7:0];
         end
      end
   end

   always_comb begin
      result.active_source = src_ff;
      result.red_level     = lvl_ff[0];
      result.green_level   = lvl_ff[1];
      result.blue_level    = lvl_ff[2];
      result.red_ramp      = FADE_DEFAULT;
      result.green_ramp    = FADE_DEFAULT;
      result.blue_ramp     = FADE_DEFAULT;
      result.on_seconds    = ON_SEC_IDLE;
      result.off_seconds   = OFF_SEC_IDLE;
      result.blink_mask    = '0;
      if (blink_ff) begin
         result.on_seconds  = onsec_ff;
         result.off_seconds = offsec_ff;
         if (bad_ff) begin
            result.red_level   = FALLBACK_LEVEL;
            result.green_level = FALLBACK_LEVEL;
            result.blue_level  = FALLBACK_LEVEL;
            result.blink_mask  = MASK_ALL;
         end else begin
            result.red_ramp   = fade_ff[0];
            result.green_ramp = fade_ff[1];
            result.blue_ramp  = fade_ff[2];
            result.blink_mask = {lvl_ff[0] != 8'd0, lvl_ff[1] != 8'd0, lvl_ff[2] != 8'd0};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_SELECT;
         ST_SELECT:  state_in = sel_blink ? ST_SNAP : ST_FINISH;
         ST_SNAP:    if (snap_done && last_col) state_in = ST_RESCALE;
         ST_RESCALE: state_in = ST_PEAK;
         ST_PEAK:    state_in = ST_FADE;
         ST_FADE:    if (fade_done && last_col) state_in = ST_FINISH;
         ST_FINISH:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      col_in       = col_ff;
      step_in      = step_ff;
      lvl_in       = lvl_ff;
      exp_in       = exp_ff;
      fade_in      = fade_ff;
      top_in       = top_ff;
      blink_in     = blink_ff;
      bad_in       = bad_ff;
      onsec_in     = onsec_ff;
      offsec_in    = offsec_ff;
      src_in       = src_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_SELECT: begin
            src_in    = source;
            blink_in  = sel_blink;
            lvl_in    = sel_lvl;
            top_in    = sel_top;
            onsec_in  = seconds_of(shown.on_ms, ON_SEC_MAX);
            offsec_in = seconds_of(shown.off_ms, OFF_SEC_MAX);
            col_in    = '0;
            step_in   = '0;
            bad_in    = 1'b0;
         end
         ST_SNAP: begin
            if (snap_done) begin
               exp_in[col_ff] = cmp_rsp.less ? step_ff : SNAP_TOP_EXP;
               step_in        = '0;
               col_in         = next_col;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_RESCALE: begin
            lvl_in = scaled;
         end
         ST_PEAK: begin
            top_in  = peak;
            col_in  = '0;
            step_in = '0;
         end
         ST_FADE: begin
            if (fade_done) begin
               step_in = '0;
               col_in  = next_col;
               if (cur_lvl == 8'd0) begin
                  fade_in[col_ff] = '0;
               end else if (cmp_rsp.equal) begin
                  fade_in[col_ff] = step_ff + 3'd1;
               end else begin
                  bad_in = 1'b1;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      exp_ff      <= exp_in;
      fade_ff     <= fade_in;
      top_ff      <= top_in;
      blink_ff    <= blink_in;
      bad_ff      <= bad_in;
      onsec_ff    <= onsec_in;
      offsec_ff   <= offsec_in;
      src_ff      <= src_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/tb.sv
// Self-checking testbench for rgb_led_breath_pattern: a directed table, then random request words.
// Predicts result words from its copy of three light slots or pinned rows; compares field by field.
// Depends on rlbp_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb;
   import rlbp_pkg::*;

   localparam int          RESET_CYCLES   = 12;
   localparam int          DIRECTED_COUNT = 23;
   localparam int          RANDOM_COUNT   = 500;
   localparam int          TAIL_CYCLES    = 50;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam logic [1:0]  MODE_SPARE     = 2'd3;

   typedef struct packed {
      req_word_type word;
      logic         pinned;
      rsp_word_type result;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   slot_type     light_slots [SLOT_COUNT];
   rsp_word_type light_expect [$];
   plan_row_type plan [$];
   int           taken = 0;
   int           words_checked = 0;
   int           blinking_words = 0;
   int           failures = 0;
   int           quiet_cycles = 0;

   plan_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{CMD_IGNORE, 24'h000000, MODE_NONE, 16'd0, 16'd0}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_BATTERY}},
      '{'{CMD_IGNORE, 24'hFFFFFF, MODE_SPARE, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'hFFFFFF, MODE_NONE, 16'd0, 16'd0}, 1'b1,
        '{8'hFF, 8'hFF, 8'hFF, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'hFF0000, MODE_TIMED, 16'd0, 16'd1000}, 1'b1,
        '{8'hFF, 8'h00, 8'h00, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'hFFFFFF, MODE_TIMED, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{8'hFF, 8'hFF, 8'hFF, 3'd1, 3'd1, 3'd1, 3'd5, 3'd7, 3'b111, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'h000000, MODE_TIMED, 16'd1, 16'd1}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'h00FF00, MODE_TIMED, 16'd999, 16'd7001}, 1'b1,
        '{8'h00, 8'hFF, 8'h00, 3'd0, 3'd1, 3'd0, 3'd1, 3'd7, 3'b010, CMD_BATTERY}},
      '{'{CMD_BATTERY, 24'h804020, MODE_TIMED, 16'd2500, 16'd3999}, 1'b0, '0},
      '{'{CMD_NOTIFY, 24'h0000FF, MODE_HW, 16'd500, 16'd0}, 1'b1,
        '{8'h00, 8'h00, 8'hFF, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_NOTIFY}},
      '{'{CMD_ATTENTION, 24'hFFFFFF, MODE_NONE, 16'd1000, 16'd1000}, 1'b1,
        '{8'h00, 8'h00, 8'hFF, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_NOTIFY}},
      '{'{CMD_ATTENTION, 24'h123456, MODE_HW, 16'd100, 16'd0}, 1'b1,
        '{8'h12, 8'h34, 8'h56, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_ATTENTION}},
      '{'{CMD_ATTENTION, 24'h00FF00, MODE_HW, 16'd0, 16'd0}, 1'b1,
        '{8'h00, 8'hFF, 8'h00, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_ATTENTION}},
      '{'{CMD_ATTENTION, 24'h808080, MODE_SPARE, 16'd2000, 16'd3000}, 1'b1,
        '{8'h80, 8'h80, 8'h80, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_ATTENTION}},
      '{'{CMD_ATTENTION, 24'h010203, MODE_TIMED, 16'd5000, 16'd1000}, 1'b0, '0},
      '{'{CMD_ATTENTION, 24'h0F0201, MODE_TIMED, 16'd3000, 16'd3000}, 1'b0, '0},
      '{'{CMD_ATTENTION, 24'hFF1400, MODE_TIMED, 16'd6000, 16'd500}, 1'b0, '0},
      '{'{CMD_ATTENTION, 24'h000000, MODE_TIMED, 16'd1000, 16'd1000}, 1'b1,
        '{8'h00, 8'h00, 8'hFF, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_NOTIFY}},
      '{'{CMD_NOTIFY, 24'h000000, MODE_NONE, 16'd0, 16'd0}, 1'b0, '0},
      '{'{CMD_NOTIFY, 24'h0C0D0C, MODE_TIMED, 16'd1500, 16'd1500}, 1'b0, '0},
      '{'{CMD_BATTERY, 24'h7F7F7F, MODE_TIMED, 16'hFFFF, 16'd0}, 1'b0, '0},
      '{'{CMD_NOTIFY, 24'h0000FF, MODE_TIMED, 16'd1000, 16'd1000}, 1'b0, '0},
      '{'{CMD_ATTENTION, 24'hAAAAAA, MODE_HW, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{8'hAA, 8'hAA, 8'hAA, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0, CMD_ATTENTION}},
      '{'{CMD_IGNORE, 24'h000000, MODE_NONE, 16'd0, 16'd0}, 1'b0, '0}
   };

   rgb_led_breath_pattern dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_word_type light_for(input slot_type s, input logic [1:0] src);
      rsp_word_type r;
      int unsigned  lv [3];
      int unsigned  grid [3];
      int unsigned  part [3];
      int unsigned  fd [3];
      int unsigned  top, lo, lo_grid, on_t, off_t, q;
      bit           unsync;
      r = '0;
      r.active_source = src;
      lv[0] = s.color[23:16];
      lv[1] = s.color[15:8];
      lv[2] = s.color[7:0];
      if (s.flash_mode == MODE_TIMED && s.on_ms != 0 && s.off_ms != 0) begin
         top = 0;
         foreach (lv[i]) if (lv[i] > top) top = lv[i];
         if (top != 0) begin
            for (int i = 0; i < 3; i++) begin
               q = lv[i] * 256 / top;
               grid[i] = 256;
               for (int g = 128; g >= 16; g = g / 2)
                  if (g + g / 2 >= q) grid[i] = g;
               if (q <= 12) grid[i] = 0;
               part[i] = grid[i] * top / 256;
            end
            lo = part[0];
            lo_grid = grid[0];
            for (int i = 1; i < 3; i++) begin
               if (part[i] != 0 && (lo == 0 || part[i] < lo)) lo = part[i];
               if (grid[i] != 0 && (lo_grid == 0 || grid[i] < lo_grid)) lo_grid = grid[i];
            end
            for (int i = 0; i < 3; i++) begin
               if (lo_grid != 0) part[i] = lo * (grid[i] / lo_grid);
               lv[i] = (part[i] > 255) ? 255 : part[i];
            end
         end
         on_t = (s.on_ms < 1000) ? 1000 : (s.on_ms > 5000) ? 5000 : s.on_ms;
         off_t = (s.off_ms < 1000) ? 1000 : (s.off_ms > 7000) ? 7000 : s.off_ms;
         top = 0;
         foreach (lv[i]) if (lv[i] > top) top = lv[i];
         unsync = 1'b0;
         for (int i = 0; i < 3; i++) begin
            fd[i] = 0;
            if (lv[i] != 0) begin
               if (top % lv[i] != 0) begin
                  unsync = 1'b1;
               end else begin
                  q = top / lv[i];
                  for (int k = 0; k <= 6; k++) if (q == (1 << k)) fd[i] = k + 1;
                  if (fd[i] == 0) unsync = 1'b1;
               end
            end
         end
         if (unsync) begin
            foreach (lv[i]) begin
               lv[i] = FALLBACK_LEVEL;
               fd[i] = FADE_DEFAULT;
            end
         end
         r.on_seconds = 3'(on_t / MS_PER_SEC);
         r.off_seconds = 3'(off_t / MS_PER_SEC);
         r.blink_mask = {lv[0] != 0, lv[1] != 0, lv[2] != 0};
      end else begin
         foreach (fd[i]) fd[i] = FADE_DEFAULT;
         r.on_seconds = ON_SEC_IDLE;
         r.off_seconds = OFF_SEC_IDLE;
         r.blink_mask = '0;
      end
      r.red_level = 8'(lv[0]);
      r.green_level = 8'(lv[1]);
      r.blue_level = 8'(lv[2]);
      r.red_ramp = 3'(fd[0]);
      r.green_ramp = 3'(fd[1]);
      r.blue_ramp = 3'(fd[2]);
      return r;
   endfunction

   function automatic logic [7:0] random_level(input logic [7:0] base);
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'($urandom_range(15, 1));
         2: return 8'(1 << $urandom_range(7));
         3, 4, 5: return base >> $urandom_range(6);
         6: return 8'($urandom_range(255));
         default: return LEVEL_MAX;
      endcase
   endfunction

   function automatic logic [15:0] random_ms();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'($urandom_range(999, 1));
         2, 3, 4: return 16'($urandom_range(7000, 1000));
         5: return 16'($urandom);
         6: return 16'hFFFF;
         default: return 16'($urandom_range(12000, 900));
      endcase
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      int unsigned  pick;
      logic [7:0]   base;
      pick = $urandom_range(19);
      w.command = (pick == 19) ? CMD_IGNORE : 2'(pick % 3);
      pick = $urandom_range(9);
      w.flash_mode = (pick < 5) ? MODE_TIMED : (pick < 7) ? MODE_NONE :
                     (pick < 9) ? MODE_HW : MODE_SPARE;
      base = 8'($urandom_range(255, 1));
      if ($urandom_range(3) == 0) w.color = 24'($urandom);
      else w.color = {random_level(base), random_level(base), random_level(base)};
      w.on_ms = random_ms();
      w.off_ms = random_ms();
      return w;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 75) return $urandom_range(3, 1);
      if (pick < 94) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_word_type want;
      slot_type     fresh;
      logic [1:0]   shown;
      if (reset) begin
         foreach (light_slots[i]) light_slots[i] = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (light_expect.size() == 0) begin
               $error("result word arrived with nothing expected");
               failures++;
            end else begin
               want = light_expect.pop_front();
               check_field("red_level", want.red_level, rsp_data.red_level);
               check_field("green_level", want.green_level, rsp_data.green_level);
               check_field("blue_level", want.blue_level, rsp_data.blue_level);
               check_field("red_ramp", want.red_ramp, rsp_data.red_ramp);
               check_field("green_ramp", want.green_ramp, rsp_data.green_ramp);
               check_field("blue_ramp", want.blue_ramp, rsp_data.blue_ramp);
               check_field("on_seconds", want.on_seconds, rsp_data.on_seconds);
               check_field("off_seconds", want.off_seconds, rsp_data.off_seconds);
               check_field("blink_mask", want.blink_mask, rsp_data.blink_mask);
               check_field("active_source", want.active_source, rsp_data.active_source);
               words_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.command != CMD_IGNORE) begin
               fresh = {req_data.color, req_data.flash_mode, req_data.on_ms, req_data.off_ms};
               if (req_data.command == CMD_ATTENTION) begin
                  if (fresh.flash_mode == MODE_HW) begin
                     if (fresh.on_ms != 0 && fresh.off_ms == 0) fresh.flash_mode = MODE_NONE;
                  end else if (fresh.flash_mode == MODE_NONE) begin
                     fresh.color = '0;
                  end
               end
               light_slots[req_data.command] = fresh;
            end
            if (light_slots[CMD_ATTENTION].color != 0) shown = CMD_ATTENTION;
            else if (light_slots[CMD_NOTIFY].color != 0) shown = CMD_NOTIFY;
            else shown = CMD_BATTERY;
            want = light_for(light_slots[shown], shown);
            if (want.blink_mask != 0) blinking_words++;
            if (taken < plan.size() && plan[taken].pinned) want = plan[taken].result;
            light_expect.push_back(want);
            taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : receiver
      forever begin
         rsp_stall <= 1'b0;
         if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(200, 60)) @(posedge clock);
         end else begin
            repeat ($urandom_range(8, 1)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (idle_span()) @(posedge clock);
         end
      end
   end

   initial begin : sender
      plan_row_type row;
      int unsigned  gap;
      bit           hold_back;
      for (int i = 0; i < DIRECTED_COUNT; i++) plan.push_back(directed_rows[i]);
      repeat (RANDOM_COUNT) begin
         row = '0;
         row.word = random_request();
         plan.push_back(row);
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) begin
         hold_back = (i == DIRECTED_COUNT) || (i % 128 == 127);
         gap = ((i / 64) % 4 == 2) ? 0 : ($urandom_range(1) ? 0 : idle_span());
         if (hold_back || gap != 0) begin
            req_valid <= 1'b0;
            if (hold_back) begin
               do @(posedge clock); while (light_expect.size() != 0);
            end
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= plan[i].word;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (light_expect.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d request words (%0d from the directed table), checked %0d result words.",
               taken, DIRECTED_COUNT, words_checked);
      $display("%0d of the expected words had at least one colour blinking.", blinking_words);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
